[src/ngf_pkg.sv]
package ngf_pkg;

  localparam int TABLE_ENTRIES = 256;
  localparam int MAX_GRAM_LEN  = 4;
  localparam int SEQ_DEPTH     = 64;
  localparam int TOKEN_BITS    = 16;

  localparam int ENTRY_AW = $clog2(TABLE_ENTRIES);
  localparam int FILL_W   = $clog2(TABLE_ENTRIES + 1);
  localparam int SEQ_AW   = $clog2(SEQ_DEPTH);
  localparam int SEQ_LW   = $clog2(SEQ_DEPTH + 1);
  localparam int LEN_W    = 4;
  localparam int WGT_W    = 17;
  localparam int CNT_W    = 16;
  localparam int FAC_W    = 16;
  localparam int SCORE_W  = WGT_W + CNT_W;
  localparam int SUM_W    = WGT_W + ENTRY_AW;

  localparam logic [WGT_W-1:0] W_STEP  = WGT_W'(655);
  localparam logic [WGT_W-1:0] W_NEW   = WGT_W'(6554);
  localparam logic [WGT_W-1:0] W_ONE   = WGT_W'(65536);
  localparam logic [WGT_W-1:0] W_FLOOR = WGT_W'(655);
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef enum logic [1:0] {
    CMD_LOAD    = 2'd0,
    CMD_EXTRACT = 2'd1,
    CMD_DECAY   = 2'd2,
    CMD_SUGGEST = 2'd3
  } cmd_t;

  localparam logic REG_ENABLE = 1'b0;

  typedef struct packed {
    logic [MAX_GRAM_LEN*TOKEN_BITS-1:0] tok;
    logic [LEN_W-1:0]                   len;
    logic [WGT_W-1:0]                   weight;
    logic [CNT_W-1:0]                   count;
  } entry_t;

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] dividend;
    logic [FILL_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [WGT_W-1:0] quotient;
  } div_rsp_t;

endpackage

[src/ngf_div.sv]
module ngf_div (
  input  logic              clk,
  input  logic              rst_n,
  input  ngf_pkg::div_req_t req,
  output ngf_pkg::div_rsp_t rsp
);
  import ngf_pkg::*;

  localparam int STEP_W = $clog2(SUM_W + 1);

  logic [SUM_W-1:0]  quo_r;
  logic [FILL_W:0]   rem_r;
  logic [FILL_W-1:0] dvs_r;
  logic [STEP_W-1:0] step_r;
  logic              run_r;
  logic              done_r;
  logic [FILL_W:0]   shifted;

  // one quotient bit per cycle, restoring
  assign shifted = {rem_r[FILL_W-1:0], quo_r[SUM_W-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        run_r  <= 1'b1;
        quo_r  <= req.dividend;
        rem_r  <= '0;
        dvs_r  <= req.divisor;
        step_r <= STEP_W'(SUM_W);
      end else if (run_r) begin
        if (shifted >= {1'b0, dvs_r}) begin
          rem_r <= shifted - {1'b0, dvs_r};
          quo_r <= {quo_r[SUM_W-2:0], 1'b1};
        end else begin
          rem_r <= shifted;
          quo_r <= {quo_r[SUM_W-2:0], 1'b0};
        end
        step_r <= step_r - 1'b1;
        if (step_r == STEP_W'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r[WGT_W-1:0];

  assert property (@(posedge clk) disable iff (!rst_n) done_r |-> !run_r)
    else $error("divider done while running");
  assert property (@(posedge clk) disable iff (!rst_n) run_r |-> step_r != '0)
    else $error("divider running with no steps left");
  assert property (@(posedge clk) disable iff (!rst_n) req.start |=> run_r)
    else $error("divider did not start");

endmodule

[src/ngram_frequency_table.sv]
// N-gram frequency table. A command is taken when start is high and busy is low;
// exactly one result follows, shown for a single cycle while out_strobe is high,
// and the receiver cannot stall it, so it must capture the result in that cycle.
// Extract, when enabled, walks every n-gram of the buffer: a step to reach each
// n-gram and another for each new length, a read and a load per token fetched from
// the sequence memory, then a read of the table memory and a compare per table entry
// searched, and a further step when the search misses and appends. Decay reads,
// multiplies and checks each entry, with a read and a copy for each removed entry
// that pulls in the last one, which is then checked in turn; a final step finishes
// the walk, then the mean divider runs when any entry is kept. Suggest, when enabled,
// reads and loads each held token of the tail (up to MAX_GRAM_LEN-1), then reads,
// multiplies and compares each entry, and a final step finishes. The table memory's
// single read port sets these steps. No clearing pass is needed after reset: table
// and buffer reads are bounded by their fill counts.
module ngram_frequency_table (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      in_command,
  input  logic [ngf_pkg::TOKEN_BITS-1:0]  in_token,
  input  logic                            in_first,
  input  logic [3:0]                      in_min_len,
  input  logic [3:0]                      in_max_len,
  input  logic [15:0]                     in_decay_factor,
  output logic                            out_strobe,
  output logic                            out_suggestion_valid,
  output logic [15:0]                     out_suggestion,
  output logic [8:0]                      out_entry_count,
  output logic [31:0]                     out_released_total,
  output logic [16:0]                     out_average_weight,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [2:0]                      paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import ngf_pkg::*;

  localparam int J_W    = $clog2(MAX_GRAM_LEN + 1);
  localparam int WIN_AW = $clog2(MAX_GRAM_LEN);

  typedef enum logic [14:0] {
    S_IDLE  = 15'b000000000000001,
    S_ENEXT = 15'b000000000000010,
    S_WRD   = 15'b000000000000100,
    S_WLD   = 15'b000000000001000,
    S_ERD   = 15'b000000000010000,
    S_ECMP  = 15'b000000000100000,
    S_DRD   = 15'b000000001000000,
    S_DMUL  = 15'b000000010000000,
    S_DCHK  = 15'b000000100000000,
    S_LRD   = 15'b000001000000000,
    S_LCP   = 15'b000010000000000,
    S_DIV   = 15'b000100000000000,
    S_SRD   = 15'b001000000000000,
    S_SMUL  = 15'b010000000000000,
    S_SCMP  = 15'b100000000000000
  } state_t;

  // configuration register
  logic enable_r;
  assign pready = 1'b1;
  assign prdata = {31'b0, enable_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b1;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_ENABLE) begin
      enable_r <= pwdata[0];
    end
  end

  // memories
  logic [TOKEN_BITS-1:0] seq_mem [SEQ_DEPTH];
  entry_t                tbl_mem [TABLE_ENTRIES];
  logic [TOKEN_BITS-1:0] seq_q;
  entry_t                rd_q;
  logic [SEQ_AW-1:0]     seq_raddr;
  logic [ENTRY_AW-1:0]   tbl_raddr;
  logic                  tbl_we;
  logic [ENTRY_AW-1:0]   tbl_waddr;
  entry_t                tbl_wdata;
  logic                  seq_we;
  logic [SEQ_AW-1:0]     seq_waddr;

  // control and datapath registers
  state_t                state_r, state_nxt;
  logic [SEQ_LW-1:0]     seq_len_r;
  logic [FILL_W-1:0]     fill_r;
  logic [31:0]           added_r;
  logic [WGT_W-1:0]      mean_r;
  logic                  strobe_r;
  logic                  sv_r;
  logic [TOKEN_BITS-1:0] sugg_r;
  logic                  sug_mode_r;
  logic [LEN_W-1:0]      n_r, hi_r;
  logic [SEQ_LW-1:0]     s_r;
  logic [J_W-1:0]        j_r, jlim_r;
  logic [FILL_W-1:0]     e_r;
  logic [FAC_W-1:0]      fac_r;
  logic [WGT_W-1:0]      prod_r;
  entry_t                cur_r;
  logic [SUM_W-1:0]      sum_r;
  logic [FILL_W-1:0]     kept_r;
  logic [SCORE_W-1:0]    best_r, score_r;
  logic                  smatch_r;
  logic [TOKEN_BITS-1:0] cand_r;
  logic [TOKEN_BITS-1:0] win_r [MAX_GRAM_LEN];

  logic                  accept;
  logic                  emat;
  logic                  smatch;
  logic [TOKEN_BITS-1:0] cand;
  logic [SEQ_LW-1:0]     seq_len_ld;
  logic [LEN_W-1:0]      lo_c, hi_c;
  logic [J_W-1:0]        tail_lim;
  logic [WGT_W+FAC_W-1:0] mul_full;
  logic [WGT_W:0]        wsum;
  div_req_t              div_req;
  div_rsp_t              div_rsp;

  assign accept = start && !busy;
  assign busy   = (state_r != S_IDLE);

  ngf_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  always_comb begin
    div_req.start    = (state_r == S_DRD) && (e_r == fill_r) && (kept_r != '0);
    div_req.dividend = sum_r;
    div_req.divisor  = kept_r;
  end

  // read address selection
  always_comb begin
    if (sug_mode_r) begin
      seq_raddr = SEQ_AW'(seq_len_r - SEQ_LW'(1) - SEQ_LW'(j_r));
    end else begin
      seq_raddr = SEQ_AW'(s_r + SEQ_LW'(j_r));
    end
    if (state_r == S_LRD) begin
      tbl_raddr = ENTRY_AW'(fill_r - FILL_W'(1));
    end else begin
      tbl_raddr = ENTRY_AW'(e_r);
    end
  end

  always_ff @(posedge clk) begin
    seq_q <= seq_mem[seq_raddr];
    rd_q  <= tbl_mem[tbl_raddr];
    if (seq_we) begin
      seq_mem[seq_waddr] <= in_token;
    end
    if (tbl_we) begin
      tbl_mem[tbl_waddr] <= tbl_wdata;
    end
  end

  // extract compare: same length and the first n tokens
  always_comb begin
    emat = (rd_q.len == n_r);
    for (int j = 0; j < MAX_GRAM_LEN; j++) begin
      if (J_W'(j) < J_W'(n_r)
          && rd_q.tok[j*TOKEN_BITS +: TOKEN_BITS] != win_r[WIN_AW'(j)]) begin
        emat = 1'b0;
      end
    end
  end

  // suggest compare: prefix against the buffer tail (win_r[k] is k-th from the end)
  always_comb begin
    int idx;
    smatch = (rd_q.len >= LEN_W'(2)) && (rd_q.len <= LEN_W'(MAX_GRAM_LEN))
          && (SEQ_LW'(rd_q.len - LEN_W'(1)) <= seq_len_r);
    cand = '0;
    for (int j = 0; j < MAX_GRAM_LEN; j++) begin
      idx = int'(rd_q.len) - 2 - j;
      if (idx >= 0 && idx < MAX_GRAM_LEN) begin
        if (rd_q.tok[j*TOKEN_BITS +: TOKEN_BITS] != win_r[WIN_AW'(idx)]) begin
          smatch = 1'b0;
        end
      end
      if (int'(rd_q.len) - 1 == j) begin
        cand = rd_q.tok[j*TOKEN_BITS +: TOKEN_BITS];
      end
    end
  end

  always_comb begin
    lo_c = (in_min_len == '0) ? LEN_W'(1) : in_min_len;
    hi_c = (in_max_len > LEN_W'(MAX_GRAM_LEN)) ? LEN_W'(MAX_GRAM_LEN) : in_max_len;
    seq_len_ld = in_first ? '0 : seq_len_r;
    tail_lim = (seq_len_r < SEQ_LW'(MAX_GRAM_LEN - 1)) ? J_W'(seq_len_r)
             : J_W'(MAX_GRAM_LEN - 1);
    mul_full = rd_q.weight * fac_r;
    wsum = {1'b0, rd_q.weight} + {1'b0, W_STEP};
    seq_we    = accept && (cmd_t'(in_command) == CMD_LOAD)
             && (seq_len_ld < SEQ_LW'(SEQ_DEPTH));
    seq_waddr = SEQ_AW'(seq_len_ld);
  end

  // table writes
  always_comb begin
    tbl_we    = 1'b0;
    tbl_waddr = ENTRY_AW'(e_r);
    tbl_wdata = rd_q;
    unique case (state_r)
      S_ERD: begin
        tbl_we = (e_r == fill_r) && (fill_r < FILL_W'(TABLE_ENTRIES));
        for (int j = 0; j < MAX_GRAM_LEN; j++) begin
          tbl_wdata.tok[j*TOKEN_BITS +: TOKEN_BITS] = win_r[WIN_AW'(j)];
        end
        tbl_wdata.len    = n_r;
        tbl_wdata.weight = W_NEW;
        tbl_wdata.count  = CNT_W'(1);
      end
      S_ECMP: begin
        tbl_we = emat;
        if (rd_q.count != CNT_MAX) tbl_wdata.count = rd_q.count + CNT_W'(1);
        tbl_wdata.weight = (wsum > {1'b0, W_ONE}) ? W_ONE : wsum[WGT_W-1:0];
      end
      S_DCHK: begin
        tbl_we           = (prod_r >= W_FLOOR);
        tbl_wdata        = cur_r;
        tbl_wdata.weight = prod_r;
      end
      S_LCP: begin
        tbl_we = 1'b1;
      end
      default: begin
        tbl_we = 1'b0;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (cmd_t'(in_command))
            CMD_LOAD:    state_nxt = S_IDLE;
            CMD_EXTRACT: state_nxt = enable_r ? S_ENEXT : S_IDLE;
            CMD_DECAY:   state_nxt = S_DRD;
            CMD_SUGGEST: begin
              if (!enable_r) state_nxt = S_IDLE;
              else if (tail_lim == '0) state_nxt = S_SRD;
              else state_nxt = S_WRD;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_ENEXT: begin
        if (n_r > hi_r || SEQ_LW'(n_r) > seq_len_r) state_nxt = S_IDLE;
        else if (s_r + SEQ_LW'(n_r) > seq_len_r) state_nxt = S_ENEXT;
        else state_nxt = S_WRD;
      end
      S_WRD: state_nxt = S_WLD;
      S_WLD: begin
        if (j_r + J_W'(1) == jlim_r) state_nxt = sug_mode_r ? S_SRD : S_ERD;
        else state_nxt = S_WRD;
      end
      S_ERD:  state_nxt = (e_r == fill_r) ? S_ENEXT : S_ECMP;
      S_ECMP: state_nxt = emat ? S_ENEXT : S_ERD;
      S_DRD: begin
        if (e_r == fill_r) state_nxt = (kept_r != '0) ? S_DIV : S_IDLE;
        else state_nxt = S_DMUL;
      end
      S_DMUL: state_nxt = S_DCHK;
      S_DCHK: begin
        if (prod_r < W_FLOOR && e_r != fill_r - FILL_W'(1)) state_nxt = S_LRD;
        else state_nxt = S_DRD;
      end
      S_LRD:  state_nxt = S_LCP;
      S_LCP:  state_nxt = S_DRD;
      S_DIV:  state_nxt = div_rsp.done ? S_IDLE : S_DIV;
      S_SRD:  state_nxt = (e_r == fill_r) ? S_IDLE : S_SMUL;
      S_SMUL: state_nxt = S_SCMP;
      S_SCMP: state_nxt = S_SRD;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      seq_len_r  <= '0;
      fill_r     <= '0;
      added_r    <= '0;
      mean_r     <= '0;
      strobe_r   <= 1'b0;
      sv_r       <= 1'b0;
      sugg_r     <= '0;
      sug_mode_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      // the strobe fires in the cycle after the command's last step
      strobe_r <= (state_r != S_IDLE || accept) && state_nxt == S_IDLE;
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            sv_r   <= 1'b0;
            sugg_r <= '0;
            n_r    <= lo_c;
            hi_r   <= hi_c;
            s_r    <= '0;
            j_r    <= '0;
            e_r    <= '0;
            fac_r  <= in_decay_factor;
            sum_r  <= '0;
            kept_r <= '0;
            best_r <= '0;
            sug_mode_r <= (cmd_t'(in_command) == CMD_SUGGEST);
            jlim_r <= tail_lim;
            if (cmd_t'(in_command) == CMD_LOAD && seq_len_ld < SEQ_LW'(SEQ_DEPTH)) begin
              seq_len_r <= seq_len_ld + SEQ_LW'(1);
            end else if (cmd_t'(in_command) == CMD_LOAD) begin
              seq_len_r <= seq_len_ld;
            end
          end
        end
        S_ENEXT: begin
          if (!(n_r > hi_r || SEQ_LW'(n_r) > seq_len_r)) begin
            if (s_r + SEQ_LW'(n_r) > seq_len_r) begin
              n_r <= n_r + LEN_W'(1);
              s_r <= '0;
            end else begin
              j_r    <= '0;
              jlim_r <= J_W'(n_r);
            end
          end
        end
        S_WLD: begin
          win_r[j_r[WIN_AW-1:0]] <= seq_q;
          j_r <= j_r + J_W'(1);
          e_r <= '0;
        end
        S_ERD: begin
          if (e_r == fill_r) begin
            if (fill_r < FILL_W'(TABLE_ENTRIES)) begin
              fill_r  <= fill_r + FILL_W'(1);
              added_r <= added_r + 32'd1;
            end
            s_r <= s_r + SEQ_LW'(1);
          end
        end
        S_ECMP: begin
          if (emat) s_r <= s_r + SEQ_LW'(1);
          else e_r <= e_r + FILL_W'(1);
        end
        S_DRD: begin
          if (e_r == fill_r && kept_r == '0) mean_r <= '0;
        end
        S_DMUL: begin
          prod_r <= mul_full[FAC_W +: WGT_W];
          cur_r  <= rd_q;
        end
        S_DCHK: begin
          if (prod_r < W_FLOOR) begin
            if (e_r == fill_r - FILL_W'(1)) fill_r <= fill_r - FILL_W'(1);
          end else begin
            sum_r  <= sum_r + SUM_W'(prod_r);
            kept_r <= kept_r + FILL_W'(1);
            e_r    <= e_r + FILL_W'(1);
          end
        end
        S_LCP: begin
          fill_r <= fill_r - FILL_W'(1);
        end
        S_DIV: begin
          if (div_rsp.done) mean_r <= div_rsp.quotient;
        end
        S_SMUL: begin
          smatch_r <= smatch;
          score_r  <= rd_q.weight * rd_q.count;
          cand_r   <= cand;
        end
        S_SCMP: begin
          if (smatch_r && score_r > best_r) begin
            best_r <= score_r;
            sugg_r <= cand_r;
            sv_r   <= 1'b1;
          end
          e_r <= e_r + FILL_W'(1);
        end
        default: begin
        end
      endcase
    end
  end

  assign out_strobe           = strobe_r;
  assign out_suggestion_valid = sv_r;
  assign out_suggestion       = sugg_r;
  assign out_entry_count      = fill_r;
  assign out_released_total   = added_r;
  assign out_average_weight   = mean_r;

  assert property (@(posedge clk) disable iff (!rst_n) fill_r <= FILL_W'(TABLE_ENTRIES))
    else $error("table fill beyond capacity");
  assert property (@(posedge clk) disable iff (!rst_n) strobe_r |-> state_r == S_IDLE)
    else $error("result shown while still working");
  assert property (@(posedge clk) disable iff (!rst_n)
      tbl_we |-> (state_r == S_ERD || state_r == S_ECMP || state_r == S_DCHK
                  || state_r == S_LCP))
    else $error("table written outside an update step");
  assert property (@(posedge clk) disable iff (!rst_n) !sv_r |-> sugg_r == '0)
    else $error("suggestion without valid flag");

endmodule

[dv/tb_ngram_frequency_table.sv]
`timescale 1ns / 1ps

module tb_ngram_frequency_table;
  import ngf_pkg::*;

  // one command request as the sender presents it
  typedef struct {
    cmd_t        command;
    logic [15:0] token;
    logic        first;
    logic [3:0]  min_len;
    logic [3:0]  max_len;
    logic [15:0] decay_factor;
  } request_t;

  // one result as the block should report it
  typedef struct {
    logic        suggestion_valid;
    logic [15:0] suggestion;
    logic [8:0]  entry_count;
    logic [31:0] released_total;
    logic [16:0] average_weight;
  } answer_t;

  localparam int WATCHDOG_CYCLES = 600000;
  localparam int DRAIN_CYCLES    = 64;
  localparam logic [2:0] ADDR_ENABLE = 3'd0;
  localparam logic [2:0] ADDR_UNUSED = 3'd4;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic [1:0]  in_command;
  logic [15:0] in_token;
  logic        in_first;
  logic [3:0]  in_min_len;
  logic [3:0]  in_max_len;
  logic [15:0] in_decay_factor;
  logic        out_strobe;
  logic        out_suggestion_valid;
  logic [15:0] out_suggestion;
  logic [8:0]  out_entry_count;
  logic [31:0] out_released_total;
  logic [16:0] out_average_weight;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  ngram_frequency_table u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_command(in_command), .in_token(in_token), .in_first(in_first),
    .in_min_len(in_min_len), .in_max_len(in_max_len), .in_decay_factor(in_decay_factor),
    .out_strobe(out_strobe), .out_suggestion_valid(out_suggestion_valid),
    .out_suggestion(out_suggestion), .out_entry_count(out_entry_count),
    .out_released_total(out_released_total), .out_average_weight(out_average_weight),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // pending requests for the driver and results still owed by the block
  request_t request_q[$];
  answer_t  answer_q[$];
  int       fail_count;
  int       idle_cycles;

  // shadow of the block: token buffer, n-gram table, counters, enable
  logic [15:0] buf_tok[SEQ_DEPTH];
  int          buf_len;
  logic [15:0] ng_tok[TABLE_ENTRIES][MAX_GRAM_LEN];
  int          ng_len[TABLE_ENTRIES];
  longint      ng_weight[TABLE_ENTRIES];
  longint      ng_freq[TABLE_ENTRIES];
  int          ng_fill;
  logic [31:0] ng_added;
  longint      ng_mean;
  logic        enabled;

  // search the table for the n-gram at buffer position pos, length n
  function automatic int match_gram(int pos, int n);
    bit same;
    for (int e = 0; e < ng_fill; e++) begin
      same = (ng_len[e] == n);
      for (int j = 0; same && j < n; j++)
        if (ng_tok[e][j] != buf_tok[pos + j]) same = 0;
      if (same) return e;
    end
    return -1;
  endfunction

  // count every n-gram of lengths lo..hi into the table
  function automatic void count_ngrams(int lo, int hi);
    int hit;
    if (lo < 1) lo = 1;
    if (hi > MAX_GRAM_LEN) hi = MAX_GRAM_LEN;
    for (int n = lo; n <= hi && n <= buf_len; n++) begin
      for (int s = 0; s + n <= buf_len; s++) begin
        hit = match_gram(s, n);
        if (hit >= 0) begin
          if (ng_freq[hit] < 65535) ng_freq[hit]++;
          ng_weight[hit] += 655;
          if (ng_weight[hit] > 65536) ng_weight[hit] = 65536;
        end else if (ng_fill < TABLE_ENTRIES) begin
          for (int j = 0; j < n; j++) ng_tok[ng_fill][j] = buf_tok[s + j];
          ng_len[ng_fill]    = n;
          ng_weight[ng_fill] = 6554;
          ng_freq[ng_fill]   = 1;
          ng_fill++;
          ng_added++;
        end
      end
    end
  endfunction

  // scale weights, swap-remove weak entries, refresh the mean
  function automatic void decay_table(longint factor);
    longint sum;
    int kept;
    int i;
    int last;
    sum = 0; kept = 0; i = 0;
    while (i < ng_fill) begin
      ng_weight[i] = (ng_weight[i] * factor) >> 16;
      if (ng_weight[i] < 655) begin
        last = ng_fill - 1;
        if (i < last) begin
          ng_tok[i]    = ng_tok[last];
          ng_len[i]    = ng_len[last];
          ng_weight[i] = ng_weight[last];
          ng_freq[i]   = ng_freq[last];
        end
        ng_fill--;
      end else begin
        sum += ng_weight[i];
        kept++;
        i++;
      end
    end
    ng_mean = kept ? sum / kept : 0;
  endfunction

  // best continuation by weight * frequency, earliest wins ties
  function automatic bit best_continuation(output logic [15:0] tok);
    longint best;
    longint score;
    int plen;
    bit same;
    bit found;
    best = 0; found = 0; tok = '0;
    for (int e = 0; e < ng_fill; e++) begin
      if (ng_len[e] < 2 || ng_len[e] > MAX_GRAM_LEN) continue;
      plen = ng_len[e] - 1;
      if (plen > buf_len) continue;
      same = 1;
      for (int j = 0; same && j < plen; j++)
        if (buf_tok[buf_len - plen + j] != ng_tok[e][j]) same = 0;
      if (!same) continue;
      score = ng_weight[e] * ng_freq[e];
      if (score > best) begin
        best  = score;
        tok   = ng_tok[e][ng_len[e] - 1];
        found = 1;
      end
    end
    return found;
  endfunction

  // apply one accepted request to the shadow and queue the result it owes
  function automatic void predict_answer(request_t r);
    answer_t a;
    logic [15:0] tok;
    a.suggestion_valid = 0;
    a.suggestion       = '0;
    case (r.command)
      CMD_LOAD: begin
        if (r.first) buf_len = 0;
        if (buf_len < SEQ_DEPTH) begin
          buf_tok[buf_len] = r.token;
          buf_len++;
        end
      end
      CMD_EXTRACT: if (enabled) count_ngrams(r.min_len, r.max_len);
      CMD_DECAY:   decay_table(r.decay_factor);
      default: begin
        if (enabled && best_continuation(tok)) begin
          a.suggestion_valid = 1;
          a.suggestion       = tok;
        end
      end
    endcase
    a.entry_count    = 9'(ng_fill);
    a.released_total = ng_added;
    a.average_weight = 17'(ng_mean);
    answer_q.push_back(a);
  endfunction

  // queue a request; unused fields get random content
  function automatic void add_request(cmd_t c, logic [15:0] tok, logic fst,
                                      int lo, int hi, int fac);
    request_t r;
    r.command      = c;
    r.token        = (c == CMD_LOAD) ? tok : 16'($urandom);
    r.first        = (c == CMD_LOAD) ? fst : 1'($urandom);
    r.min_len      = (c == CMD_EXTRACT) ? 4'(lo) : 4'($urandom_range(0, 8));
    r.max_len      = (c == CMD_EXTRACT) ? 4'(hi) : 4'($urandom_range(0, 8));
    r.decay_factor = (c == CMD_DECAY) ? 16'(fac) : 16'($urandom);
    request_q.push_back(r);
  endfunction

  // mostly a small alphabet so n-grams repeat, sometimes any 16-bit id
  function automatic logic [15:0] pick_token();
    if ($urandom_range(0, 9) == 0) return 16'($urandom);
    return 16'($urandom_range(0, 5));
  endfunction

  // a well-formed phrase: fresh buffer, extract, then a few suggestions
  function automatic void add_phrase();
    int n;
    n = $urandom_range(1, 6);
    add_request(CMD_LOAD, pick_token(), 1, 0, 0, 0);
    for (int i = 1; i < n; i++) add_request(CMD_LOAD, pick_token(), 0, 0, 0, 0);
    add_request(CMD_EXTRACT, 0, 0, $urandom_range(0, 2), $urandom_range(2, 8), 0);
    for (int i = $urandom_range(0, 2); i > 0; i--) begin
      add_request(CMD_LOAD, pick_token(), 0, 0, 0, 0);
      add_request(CMD_SUGGEST, 0, 0, 0, 0, 0);
    end
    add_request(CMD_SUGGEST, 0, 0, 0, 0, 0);
  endfunction

  // noise: any command with random field values
  function automatic void add_noise();
    add_request(cmd_t'($urandom_range(0, 3)), pick_token(), 1'($urandom),
                $urandom_range(0, 8), $urandom_range(0, 8),
                ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(40000, 65535));
  endfunction

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // sender: one request per handshake, random gaps, bursts without gaps
  int  gap_left;
  bit  burst_mode;
  always @(posedge clk) begin
    logic next_start;
    request_t r;
    if (!rst_n) begin
      start      <= 0;
      gap_left   <= 0;
      burst_mode <= 0;
    end else begin
      next_start = start;
      if (start && !busy) begin
        predict_answer(request_q.pop_front());
        next_start = 0;
      end
      if (!next_start) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
        end else if (request_q.size() > 0) begin
          r = request_q[0];
          in_command      <= r.command;
          in_token        <= r.token;
          in_first        <= r.first;
          in_min_len      <= r.min_len;
          in_max_len      <= r.max_len;
          in_decay_factor <= r.decay_factor;
          next_start = 1;
          if ($urandom_range(0, 49) == 0) burst_mode <= ~burst_mode;
          if (burst_mode) gap_left <= 0;
          else if ($urandom_range(0, 19) == 0) gap_left <= $urandom_range(10, 60);
          else gap_left <= $urandom_range(0, 3);
        end
      end
      start <= next_start;
    end
  end

  // receiver: results are shown for one cycle and cannot be held off
  always @(posedge clk) begin
    answer_t a;
    if (rst_n && out_strobe) begin
      if (answer_q.size() == 0) begin
        $error("result with no request outstanding");
        fail_count++;
      end else begin
        a = answer_q.pop_front();
        if (out_suggestion_valid !== a.suggestion_valid) begin
          $error("suggestion_valid exp %0d got %0d", a.suggestion_valid, out_suggestion_valid);
          fail_count++;
        end
        if (out_suggestion !== a.suggestion) begin
          $error("suggestion exp %0d got %0d", a.suggestion, out_suggestion);
          fail_count++;
        end
        if (out_entry_count !== a.entry_count) begin
          $error("entry_count exp %0d got %0d", a.entry_count, out_entry_count);
          fail_count++;
        end
        if (out_released_total !== a.released_total) begin
          $error("released_total exp %0d got %0d", a.released_total, out_released_total);
          fail_count++;
        end
        if (out_average_weight !== a.average_weight) begin
          $error("average_weight exp %0d got %0d", a.average_weight, out_average_weight);
          fail_count++;
        end
      end
    end
  end

  // watchdog: a full-table extract is the longest silent stretch
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe || psel) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

  // wait until every request is taken and answered, then let the block settle
  task automatic drain();
    while (request_q.size() > 0 || answer_q.size() > 0 || start || busy) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // register write: setup cycle then access cycle
  task automatic reg_write(logic [2:0] addr, logic [31:0] data);
    @(posedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= addr; pwdata <= data;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr == ADDR_ENABLE) enabled = data[0];
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  initial begin
    rst_n = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    in_command = '0; in_token = '0; in_first = 0;
    in_min_len = '0; in_max_len = '0; in_decay_factor = '0;
    fail_count = 0; idle_cycles = 0;
    buf_len = 0; ng_fill = 0; ng_added = '0; ng_mean = 0; enabled = 1;
    repeat (2) @(posedge clk);
    rst_n <= 1;

    // directed: empty table, extremes of tokens and lengths
    add_request(CMD_SUGGEST, 0, 0, 0, 0, 0);
    add_request(CMD_EXTRACT, 0, 0, 0, 8, 0);
    add_request(CMD_DECAY, 0, 0, 0, 0, 65535);
    add_request(CMD_LOAD, 16'h0000, 1, 0, 0, 0);
    add_request(CMD_LOAD, 16'hffff, 0, 0, 0, 0);
    add_request(CMD_LOAD, 16'h0000, 0, 0, 0, 0);
    add_request(CMD_EXTRACT, 0, 0, 0, 8, 0);
    add_request(CMD_EXTRACT, 0, 0, 5, 2, 0);
    add_request(CMD_EXTRACT, 0, 0, 8, 8, 0);
    add_request(CMD_EXTRACT, 0, 0, 2, 3, 0);
    add_request(CMD_SUGGEST, 0, 0, 0, 0, 0);
    add_request(CMD_LOAD, 16'hffff, 0, 0, 0, 0);
    add_request(CMD_SUGGEST, 0, 0, 0, 0, 0);
    add_request(CMD_LOAD, 16'h1234, 1, 0, 0, 0);
    add_request(CMD_EXTRACT, 0, 0, 4, 4, 0);
    add_request(CMD_SUGGEST, 0, 0, 0, 0, 0);
    add_request(CMD_DECAY, 0, 0, 0, 0, 60000);
    add_request(CMD_DECAY, 0, 0, 0, 0, 0);
    drain();

    // disabled block: extract and suggest do nothing, load and decay still act
    reg_write(ADDR_ENABLE, 32'd0);
    add_request(CMD_LOAD, 16'd3, 1, 0, 0, 0);
    add_request(CMD_LOAD, 16'd4, 0, 0, 0, 0);
    add_request(CMD_EXTRACT, 0, 0, 1, 4, 0);
    add_request(CMD_SUGGEST, 0, 0, 0, 0, 0);
    add_request(CMD_DECAY, 0, 0, 0, 0, 50000);
    drain();
    reg_write(ADDR_UNUSED, 32'd1);
    add_request(CMD_EXTRACT, 0, 0, 1, 4, 0);
    add_request(CMD_SUGGEST, 0, 0, 0, 0, 0);
    drain();
    reg_write(ADDR_ENABLE, 32'hffff_ffff);

    // full buffer, then full table: 250 distinct n-grams, then 64 more singles, of which 6 fit
    for (int i = 0; i < SEQ_DEPTH + 2; i++)
      add_request(CMD_LOAD, 16'(16'h1000 + i), i == 0, 0, 0, 0);
    add_request(CMD_EXTRACT, 0, 0, 1, 4, 0);
    for (int i = 0; i < SEQ_DEPTH; i++)
      add_request(CMD_LOAD, 16'(16'h2000 + i), i == 0, 0, 0, 0);
    add_request(CMD_EXTRACT, 0, 0, 1, 1, 0);
    add_request(CMD_SUGGEST, 0, 0, 0, 0, 0);
    add_request(CMD_DECAY, 0, 0, 0, 0, 0);
    drain();

    // random phrases with noise, the enable register toggled between phases
    for (int phase = 0; phase < 6; phase++) begin
      for (int k = 0; k < 46; ) begin
        if ($urandom_range(0, 4) == 0) begin
          add_noise();
          k++;
        end else begin
          add_phrase();
          k += 5;
        end
        if ($urandom_range(0, 9) == 0)
          add_request(CMD_DECAY, 0, 0, 0, 0,
                      ($urandom_range(0, 4) == 0) ? $urandom_range(0, 65535)
                                                  : $urandom_range(50000, 65535));
      end
      drain();
      reg_write(ADDR_ENABLE, (phase % 3 == 1) ? 32'd0 : 32'd1);
    end
    reg_write(ADDR_ENABLE, 32'd1);
    add_phrase();
    drain();

    if (fail_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

[filelist.f]
src/ngf_pkg.sv
src/ngf_div.sv
src/ngram_frequency_table.sv
dv/tb_ngram_frequency_table.sv
